### hdl/utp_pkg.sv
// shared types, codes and character class functions for the utf-8 paginator
`default_nettype none
package utp_pkg;

   localparam int CP_BITS = 21;
   localparam int UNITS_BITS = 18;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_REPLAY = 2'd1;
   localparam logic [1:0] OP_MAIN = 2'd2;

   localparam logic [0:0] REG_LINE_WIDTH = 1'd0;
   localparam logic [0:0] REG_PAGE_HEIGHT = 1'd1;

   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_END = 8'h00;

   typedef struct packed {
      logic [1:0] op;
      logic use_latched;
      logic latch;
      logic [1:0] replay_idx;
   } cmd_type;

   typedef struct packed {
      logic can_emit;
      logic need_replay;
      logic [1:0] held_count;
   } status_type;

   function automatic logic [1:0] units_of(input logic [CP_BITS-1:0] cp);
      logic wide;
      begin
         wide = (cp >= 21'h01100 && cp <= 21'h0115F) ||
                (cp >= 21'h02E80 && cp <= 21'h0A4CF && cp != 21'h0303F) ||
                (cp >= 21'h0AC00 && cp <= 21'h0D7A3) ||
                (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
                (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
                (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
                (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
                (cp >= 21'h20000 && cp <= 21'h3FFFD);
         units_of = wide ? 2'd2 : 2'd1;
      end
   endfunction

   function automatic logic is_closing(input logic [CP_BITS-1:0] cp);
      begin
         case (cp) inside
            21'h03001, 21'h03002, 21'h0300D, 21'h0300F, 21'h03011, 21'h03015,
            21'h0FF01, 21'h0FF09, 21'h0FF0C, 21'h0FF0E, 21'h0FF1A, 21'h0FF1B,
            21'h0FF1F, 21'h0FF3D, 21'h02019, 21'h0201D, 21'h02026, 21'h02014,
            21'h030FC: is_closing = 1'b1;
            default: is_closing = 1'b0;
         endcase
      end
   endfunction

endpackage
`default_nettype wire

### hdl/utp_channels.sv
// request and response channel interfaces of the paginator
`default_nettype none
interface utp_req_if;
   logic valid;
   logic ready;
   logic [7:0] text_byte;
   logic terminator;
   modport source (output valid, output text_byte, output terminator, input ready);
   modport sink (input valid, input text_byte, input terminator, output ready);
endinterface

interface utp_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] page_index;
   logic [15:0] byte_offset;
   logic is_final;
   modport source (output valid, output page_index, output byte_offset, output is_final,
                   input ready);
   modport sink (input valid, input page_index, input byte_offset, input is_final,
                 output ready);
endinterface
`default_nettype wire

### hdl/utp_controller.sv
// sequencer: takes beats, steps through replay of held bytes, then the main step
`default_nettype none
module utp_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire utp_pkg::status_type  status,
   output utp_pkg::cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REPLAY = 2'd1;
   localparam logic [1:0] ST_MAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      req_ready = 1'b0;
      cmd.op = utp_pkg::OP_NONE;
      cmd.use_latched = 1'b0;
      cmd.latch = 1'b0;
      cmd.replay_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.can_emit && !reset;
            if (req_valid && req_ready) begin
               if (status.need_replay) begin
                  cmd.latch = 1'b1;
                  idx_in = 2'd0;
                  state_in = ST_REPLAY;
               end else begin
                  cmd.op = utp_pkg::OP_MAIN;
               end
            end
         end
         ST_REPLAY: begin
            if (status.can_emit) begin
               cmd.op = utp_pkg::OP_REPLAY;
               if (idx_ff == status.held_count - 2'd1) begin
                  state_in = ST_MAIN;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ST_MAIN: begin
            if (status.can_emit) begin
               cmd.op = utp_pkg::OP_MAIN;
               cmd.use_latched = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

### hdl/utp_datapath.sv
// decoder, layout counters, config registers and result register
`default_nettype none
module utp_datapath #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [0:0]           csr_index,
   input  wire logic [15:0]          csr_write_data,
   input  wire logic [7:0]           req_text_byte,
   input  wire logic                 req_terminator,
   input  wire utp_pkg::cmd_type     cmd,
   output utp_pkg::status_type       status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [15:0]               rsp_page_index,
   output logic [15:0]               rsp_byte_offset,
   output logic                      rsp_is_final
);

   localparam int P = POSITION_BITS;
   localparam int EXT_BITS = P + 16;
   localparam int CPB = utp_pkg::CP_BITS;
   localparam int UB = utp_pkg::UNITS_BITS;

   logic [15:0] width_ff, height_ff;
   logic [P-1:0] pos_ff, pos_in;
   logic [7:0] held_ff [0:2];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [2:0] seq_len_ff, seq_len_in;
   logic [CPB-1:0] partial_ff, partial_in;
   logic [15:0] page_ff, page_in;
   logic [15:0] line_ff, line_in;
   logic [UB-1:0] units_ff, units_in;
   logic [7:0] lat_byte_ff;
   logic lat_term_ff;
   logic rsp_valid_ff;
   logic [15:0] rsp_page_ff, rsp_offset_ff;
   logic rsp_final_ff;

   logic [7:0] cur_byte;
   logic cur_term;
   logic [7:0] replay_byte;
   logic do_place, do_newline, do_final;
   logic [CPB-1:0] place_cp;
   logic [2:0] place_len;
   logic held_we;
   logic [1:0] held_waddr;
   logic [CPB-1:0] part_next;

   logic [1:0] units_add;
   logic [UB:0] units_sum;
   logic [UB-1:0] units_sat;
   logic wrap;
   logic [2:0] add_amt;
   logic [P:0] pos_sum;
   logic [P-1:0] pos_add;
   logic end_req;
   logic [P-1:0] end_off;
   logic [15:0] line_inc, page_inc;
   logic page_hit;
   logic emit;
   logic [EXT_BITS-1:0] clip_src;
   logic [15:0] clip_val;

   assign status.can_emit = !rsp_valid_ff || rsp_ready;
   assign status.need_replay = (held_cnt_ff != 2'd0) &&
      (req_terminator || req_text_byte == utp_pkg::BYTE_END || req_text_byte[7:6] != 2'b10);
   assign status.held_count = held_cnt_ff;

   assign cur_byte = cmd.use_latched ? lat_byte_ff : req_text_byte;
   assign cur_term = cmd.use_latched ? lat_term_ff : req_terminator;
   assign replay_byte = (cmd.replay_idx == 2'd2) ? held_ff[2] :
                        (cmd.replay_idx == 2'd1) ? held_ff[1] : held_ff[0];
   assign part_next = {partial_ff[CPB-7:0], cur_byte[5:0]};

   // byte decode
   always_comb begin
      do_place = 1'b0;
      do_newline = 1'b0;
      do_final = 1'b0;
      place_cp = '0;
      place_len = 3'd1;
      held_we = 1'b0;
      held_waddr = 2'd0;
      held_cnt_in = held_cnt_ff;
      seq_len_in = seq_len_ff;
      partial_in = partial_ff;
      case (cmd.op)
         utp_pkg::OP_REPLAY: begin
            do_place = 1'b1;
            place_cp = CPB'(replay_byte);
         end
         utp_pkg::OP_MAIN: begin
            if (cur_term || cur_byte == utp_pkg::BYTE_END) begin
               do_final = 1'b1;
               held_cnt_in = 2'd0;
               seq_len_in = 3'd0;
               partial_in = '0;
            end else if (held_cnt_ff != 2'd0 && cur_byte[7:6] == 2'b10) begin
               if (3'(held_cnt_ff) + 3'd1 >= seq_len_ff) begin
                  do_place = 1'b1;
                  place_cp = part_next;
                  place_len = seq_len_ff;
                  held_cnt_in = 2'd0;
                  seq_len_in = 3'd0;
                  partial_in = '0;
               end else begin
                  held_we = (held_cnt_ff != 2'd3);
                  held_waddr = held_cnt_ff;
                  held_cnt_in = held_cnt_ff + 2'd1;
                  partial_in = part_next;
               end
            end else begin
               held_cnt_in = 2'd0;
               seq_len_in = 3'd0;
               partial_in = '0;
               if (cur_byte == utp_pkg::BYTE_NEWLINE) begin
                  do_newline = 1'b1;
               end else if (cur_byte[7:5] == 3'b110) begin
                  seq_len_in = 3'd2;
                  partial_in = CPB'(cur_byte[4:0]);
                  held_we = 1'b1;
                  held_cnt_in = 2'd1;
               end else if (cur_byte[7:4] == 4'b1110) begin
                  seq_len_in = 3'd3;
                  partial_in = CPB'(cur_byte[3:0]);
                  held_we = 1'b1;
                  held_cnt_in = 2'd1;
               end else if (cur_byte[7:3] == 5'b11110) begin
                  seq_len_in = 3'd4;
                  partial_in = CPB'(cur_byte[2:0]);
                  held_we = 1'b1;
                  held_cnt_in = 2'd1;
               end else begin
                  do_place = 1'b1;
                  place_cp = CPB'(cur_byte);
               end
            end
         end
         default: begin
            do_place = 1'b0;
         end
      endcase
   end

   // layout arithmetic
   assign units_add = utp_pkg::units_of(place_cp);
   assign units_sum = {1'b0, units_ff} + (UB+1)'(units_add);
   assign units_sat = units_sum[UB] ? {UB{1'b1}} : units_sum[UB-1:0];
   assign wrap = do_place && units_ff != '0 && width_ff != 16'd0 &&
                 units_sum > (UB+1)'(width_ff) && !utp_pkg::is_closing(place_cp);
   assign add_amt = do_newline ? 3'd1 : place_len;
   assign pos_sum = {1'b0, pos_ff} + (P+1)'(add_amt);
   assign pos_add = pos_sum[P] ? {P{1'b1}} : pos_sum[P-1:0];
   assign end_req = wrap || do_newline;
   assign end_off = do_newline ? pos_add : pos_ff;
   assign line_inc = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
   assign page_inc = (page_ff == 16'hFFFF) ? page_ff : page_ff + 16'd1;
   assign page_hit = end_req && height_ff != 16'd0 && line_inc >= height_ff;
   assign emit = page_hit || do_final;
   assign clip_src = EXT_BITS'(do_final ? pos_ff : end_off);
   assign clip_val = (clip_src > EXT_BITS'(16'hFFFF)) ? 16'hFFFF : clip_src[15:0];

   always_comb begin
      pos_in = (do_place || do_newline) ? pos_add : pos_ff;
      units_in = do_newline ? '0 : do_place ? (wrap ? UB'(units_add) : units_sat) : units_ff;
      line_in = end_req ? (page_hit ? 16'd0 : line_inc) : line_ff;
      page_in = page_hit ? page_inc : page_ff;
      if (do_final) begin
         pos_in = '0;
         units_in = '0;
         line_in = 16'd0;
         page_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 16'd0;
         height_ff <= 16'd0;
         pos_ff <= '0;
         held_cnt_ff <= 2'd0;
         seq_len_ff <= 3'd0;
         partial_ff <= '0;
         page_ff <= 16'd0;
         line_ff <= 16'd0;
         units_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               utp_pkg::REG_LINE_WIDTH: width_ff <= csr_write_data;
               utp_pkg::REG_PAGE_HEIGHT: height_ff <= csr_write_data;
               default: width_ff <= width_ff;
            endcase
         end
         pos_ff <= pos_in;
         held_cnt_ff <= held_cnt_in;
         seq_len_ff <= seq_len_in;
         partial_ff <= partial_in;
         page_ff <= page_in;
         line_ff <= line_in;
         units_ff <= units_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[held_waddr] <= cur_byte;
      end
      if (cmd.latch) begin
         lat_byte_ff <= req_text_byte;
         lat_term_ff <= req_terminator;
      end
      if (emit) begin
         rsp_page_ff <= do_final ? page_inc : page_inc;
         rsp_offset_ff <= clip_val;
         rsp_final_ff <= do_final;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_page_index = rsp_page_ff;
   assign rsp_byte_offset = rsp_offset_ff;
   assign rsp_is_final = rsp_final_ff;

endmodule
`default_nettype wire

### hdl/utf8_text_paginator.sv
// top level of the utf-8 text paginator
//
//   channel  dir  beat contents
//   req_if   in   text_byte[7:0], terminator
//   rsp_if   out  page_index[15:0], byte_offset[15:0], is_final
//   csr_*    in   csr_index 0 line width, 1 page height; csr_write_data[15:0]
//
// an ordinary byte is placed as it is accepted; a byte that breaks a held sequence, or an
// end of text with bytes held, is latched on acceptance, then each held byte (up to
// three) goes through the shared placement unit, and then the byte itself
// each step emits at most one result; a step waits while the result register is full
// synchronous active-high reset clears the counters, the config registers and the result valid flag
`default_nettype none
module utf8_text_paginator #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   utp_req_if.sink           req_if,
   utp_rsp_if.source         rsp_if,
   input  wire logic         csr_write_en,
   input  wire logic [0:0]   csr_index,
   input  wire logic [15:0]  csr_write_data
);

   utp_pkg::cmd_type cmd;
   utp_pkg::status_type status;
   logic req_ready;
   logic rsp_valid;
   logic [15:0] rsp_page_index;
   logic [15:0] rsp_byte_offset;
   logic rsp_is_final;

   utp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   utp_datapath #(
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_text_byte   (req_if.text_byte),
      .req_terminator  (req_if.terminator),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_page_index  (rsp_page_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_is_final    (rsp_is_final)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;
   assign rsp_if.page_index = rsp_page_index;
   assign rsp_if.byte_offset = rsp_byte_offset;
   assign rsp_if.is_final = rsp_is_final;

endmodule
`default_nettype wire

### sim/utf8_text_paginator_tb.sv
// testbench for the utf-8 text paginator: streams text bytes and checks page starts
module utf8_text_paginator_tb;

   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int POS_MAX = 65535;
   localparam int UNITS_MAX = 262143;
   localparam int COUNT_MAX = 65535;
   localparam int MAX_PAGES_PER_BEAT = 5;

   localparam logic [20:0] CLOSING_MARKS [0:18] = '{
      21'h03001, 21'h03002, 21'h0300D, 21'h0300F, 21'h03011, 21'h03015, 21'h0FF01,
      21'h0FF09, 21'h0FF0C, 21'h0FF0E, 21'h0FF1A, 21'h0FF1B, 21'h0FF1F, 21'h0FF3D,
      21'h02019, 21'h0201D, 21'h02026, 21'h02014, 21'h030FC
   };

   typedef struct packed {
      logic [15:0] page_index;
      logic [15:0] byte_offset;
      logic is_final;
   } page_beat_type;

   class page_tracker_type;
      page_beat_type pages_due[$];
      int errors;
      int unsigned line_width, page_height;
      int unsigned byte_pos, held_n, seq_len, page_no, line_no, units_used, emitted;
      logic [7:0] held [0:2];
      logic [20:0] partial_cp;

      function new();
         errors = 0;
         line_width = 0;
         page_height = 0;
         clear_run();
      endfunction

      function void clear_run();
         byte_pos = 0;
         held_n = 0;
         seq_len = 0;
         partial_cp = '0;
         page_no = 0;
         line_no = 0;
         units_used = 0;
      endfunction

      function void set_register(logic [0:0] idx, logic [15:0] value);
         case (idx)
            utp_pkg::REG_LINE_WIDTH: line_width = {16'd0, value};
            utp_pkg::REG_PAGE_HEIGHT: page_height = {16'd0, value};
            default: ;
         endcase
      endfunction

      function logic [15:0] clip16(int unsigned v);
         return (v > COUNT_MAX) ? 16'hFFFF : v[15:0];
      endfunction

      function void expect_page(int unsigned page, int unsigned offset, logic fin);
         page_beat_type beat;
         if (emitted >= MAX_PAGES_PER_BEAT) return;
         beat.page_index = clip16(page);
         beat.byte_offset = clip16(offset);
         beat.is_final = fin;
         pages_due.push_back(beat);
         emitted++;
      endfunction

      function int unsigned units_for(logic [20:0] cp);
         if (cp < 21'h00080) return 1;
         if ((cp >= 21'h01100 && cp <= 21'h0115F) ||
             (cp >= 21'h02E80 && cp <= 21'h0A4CF && cp != 21'h0303F) ||
             (cp >= 21'h0AC00 && cp <= 21'h0D7A3) ||
             (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
             (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
             (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
             (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
             (cp >= 21'h20000 && cp <= 21'h3FFFD))
            return 2;
         return 1;
      endfunction

      function bit is_closer(logic [20:0] cp);
         for (int i = 0; i < 19; i++) begin
            if (CLOSING_MARKS[5'(i)] == cp) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void close_line(int unsigned offset);
         units_used = 0;
         if (line_no < COUNT_MAX) line_no++;
         if (page_height == 0 || line_no < page_height) return;
         if (page_no < COUNT_MAX) page_no++;
         line_no = 0;
         expect_page(page_no, offset, 1'b0);
      endfunction

      function void place_char(logic [20:0] cp, int unsigned len);
         int unsigned u;
         u = units_for(cp);
         if (units_used > 0 && line_width != 0 && units_used + u > line_width && !is_closer(cp))
            close_line(byte_pos);
         units_used = (units_used + u > UNITS_MAX) ? UNITS_MAX : units_used + u;
         byte_pos = (byte_pos + len > POS_MAX) ? POS_MAX : byte_pos + len;
      endfunction

      function void replay_held();
         for (int i = 0; i < held_n && i < 3; i++) begin
            place_char({13'd0, held[2'(i)]}, 1);
         end
         held_n = 0;
         seq_len = 0;
         partial_cp = '0;
      endfunction

      function void start_byte(logic [7:0] b);
         if (b == utp_pkg::BYTE_NEWLINE) begin
            byte_pos = (byte_pos + 1 > POS_MAX) ? POS_MAX : byte_pos + 1;
            close_line(byte_pos);
         end else if (b[7:5] == 3'b110) begin
            seq_len = 2;
            partial_cp = {16'd0, b[4:0]};
            held[0] = b;
            held_n = 1;
         end else if (b[7:4] == 4'b1110) begin
            seq_len = 3;
            partial_cp = {17'd0, b[3:0]};
            held[0] = b;
            held_n = 1;
         end else if (b[7:3] == 5'b11110) begin
            seq_len = 4;
            partial_cp = {18'd0, b[2:0]};
            held[0] = b;
            held_n = 1;
         end else begin
            place_char({13'd0, b}, 1);
         end
      endfunction

      function void take_byte(logic [7:0] b, logic term);
         logic [20:0] cp_done;
         int unsigned len_done;
         emitted = 0;
         if (term || b == utp_pkg::BYTE_END) begin
            replay_held();
            expect_page(page_no + 1, byte_pos, 1'b1);
            clear_run();
            return;
         end
         if (held_n > 0) begin
            if (b[7:6] == 2'b10) begin
               partial_cp = {partial_cp[14:0], b[5:0]};
               if (held_n + 1 >= seq_len) begin
                  cp_done = partial_cp;
                  len_done = seq_len;
                  held_n = 0;
                  seq_len = 0;
                  partial_cp = '0;
                  place_char(cp_done, len_done);
               end else begin
                  if (held_n < 3) held[2'(held_n)] = b;
                  held_n++;
               end
               return;
            end
            replay_held();
         end
         start_byte(b);
      endfunction

      function void flag_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void match_page(logic [15:0] page, logic [15:0] offset, logic fin);
         page_beat_type want;
         if (pages_due.size() == 0) begin
            errors++;
            $display("%0t beat expected none actual page_index %0d byte_offset %0d is_final %0d",
                     $time, page, offset, fin);
            return;
         end
         want = pages_due.pop_front();
         flag_field("page_index", want.page_index, page);
         flag_field("byte_offset", want.byte_offset, offset);
         flag_field("is_final", {15'd0, want.is_final}, {15'd0, fin});
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [0:0] csr_index;
   logic [15:0] csr_write_data;

   utp_req_if req_ch ();
   utp_rsp_if rsp_ch ();

   page_tracker_type book;
   int beats_sent = 0;
   int unsigned burst_left = 0;
   bit steady = 1'b0;
   bit hold_armed = 1'b0;
   int quiet_cycles = 0;

   utf8_text_paginator dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         book.match_page(rsp_ch.page_index, rsp_ch.byte_offset, rsp_ch.is_final);
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver: runs of always-ready, random and alternating stalls, plus one long hold-off
   initial begin : result_sink
      int run_len, mode, n;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         if (hold_armed && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            run_len = $urandom_range(1, 30);
            n = 0;
            while (n < run_len && !(hold_armed && !hold_done)) begin
               case (mode)
                  0: rsp_ch.ready <= 1'b1;
                  1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ch.ready <= 1'($urandom_range(0, 1));
                  default: rsp_ch.ready <= n[0];
               endcase
               @(posedge clock);
               n++;
            end
         end
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic term);
      int gap;
      if (!steady && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= b;
      req_ch.terminator <= term;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      book.take_byte(b, term);
      beats_sent++;
   endtask

   task automatic send_code(input logic [20:0] cp, input int len);
      case (len)
         2: begin
            send_beat({3'b110, cp[10:6]}, 1'b0);
            send_beat({2'b10, cp[5:0]}, 1'b0);
         end
         3: begin
            send_beat({4'b1110, cp[15:12]}, 1'b0);
            send_beat({2'b10, cp[11:6]}, 1'b0);
            send_beat({2'b10, cp[5:0]}, 1'b0);
         end
         default: begin
            send_beat({5'b11110, cp[20:18]}, 1'b0);
            send_beat({2'b10, cp[17:12]}, 1'b0);
            send_beat({2'b10, cp[11:6]}, 1'b0);
            send_beat({2'b10, cp[5:0]}, 1'b0);
         end
      endcase
   endtask

   task automatic send_char();
      int pick, len;
      logic [20:0] cp;
      logic [31:0] noise;
      pick = $urandom_range(0, 99);
      noise = $urandom;
      if (pick < 35) begin
         send_beat(noise[6:0] == 7'd0 ? 8'h20 : {1'b0, noise[6:0]}, 1'b0);
      end else if (pick < 45) begin
         send_beat(utp_pkg::BYTE_NEWLINE, 1'b0);
      end else if (pick < 55) begin
         send_code(noise[20:0] & 21'h007FF, 2);
      end else if (pick < 70) begin
         case ($urandom_range(0, 2))
            0: cp = 21'($urandom_range(21'h02E80, 21'h0A4CF));
            1: cp = 21'($urandom_range(21'h0AC00, 21'h0D7A3));
            default: cp = noise[20:0] & 21'h0FFFF;
         endcase
         send_code(cp, 3);
      end else if (pick < 78) begin
         send_code(CLOSING_MARKS[5'($urandom_range(0, 18))], 3);
      end else if (pick < 86) begin
         cp = noise[31] ? 21'($urandom_range(21'h20000, 21'h3FFFF)) : noise[20:0];
         send_code(cp, 4);
      end else if (pick < 94) begin
         // lead byte cut short by whatever comes next
         len = $urandom_range(2, 4);
         case (len)
            2: send_beat({3'b110, noise[4:0]}, 1'b0);
            3: send_beat({4'b1110, noise[3:0]}, 1'b0);
            default: send_beat({5'b11110, noise[2:0]}, 1'b0);
         endcase
         repeat ($urandom_range(0, len - 2)) begin
            noise = $urandom;
            send_beat({2'b10, noise[5:0]}, 1'b0);
         end
      end else begin
         send_beat(noise[31] ? {2'b10, noise[5:0]} : {5'b11111, noise[2:0]}, 1'b0);
      end
   endtask

   task automatic settle();
      while (book.pages_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic finish_phase(input bit with_end);
      logic [7:0] junk;
      junk = 8'($urandom);
      if (with_end) begin
         if ($urandom_range(0, 1)) send_beat(junk, 1'b1);
         else send_beat(utp_pkg::BYTE_END, 1'b0);
      end
      req_ch.valid <= 1'b0;
      settle();
   endtask

   task automatic set_layout(input logic [15:0] width_units, input logic [15:0] height_lines);
      csr_write_en <= 1'b1;
      csr_index <= utp_pkg::REG_LINE_WIDTH;
      csr_write_data <= width_units;
      @(posedge clock);
      csr_index <= utp_pkg::REG_PAGE_HEIGHT;
      csr_write_data <= height_lines;
      @(posedge clock);
      csr_write_en <= 1'b0;
      book.set_register(utp_pkg::REG_LINE_WIDTH, width_units);
      book.set_register(utp_pkg::REG_PAGE_HEIGHT, height_lines);
   endtask

   initial begin : text_source
      int phase, start;
      logic [15:0] width_pick, height_pick;
      book = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.text_byte <= 8'h00;
      req_ch.terminator <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= utp_pkg::REG_LINE_WIDTH;
      csr_write_data <= 16'h0000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_layout(16'd4, 16'd1);
      send_beat(8'h41, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_code(21'h04E00, 3);
      send_code(21'h03001, 3);
      send_beat(8'h80, 1'b0);
      send_beat(utp_pkg::BYTE_NEWLINE, 1'b0);
      send_code(21'h000E9, 2);
      send_code(21'h20000, 4);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hE4, 1'b0);
      send_beat(8'h41, 1'b0);
      send_beat(8'hF8, 1'b0);
      send_code(21'h00000, 2);
      send_beat(8'hE4, 1'b0);
      send_beat(8'hB8, 1'b0);
      send_beat(8'hFF, 1'b1);
      finish_phase(1'b1);

      // layout change in the middle of a run, past the new page height
      set_layout(16'd0, 16'd0);
      send_beat(8'h61, 1'b0);
      send_beat(utp_pkg::BYTE_NEWLINE, 1'b0);
      send_beat(utp_pkg::BYTE_NEWLINE, 1'b0);
      send_beat(utp_pkg::BYTE_NEWLINE, 1'b0);
      send_code(21'h0AC01, 3);
      finish_phase(1'b0);
      set_layout(16'd3, 16'd2);
      send_beat(8'h78, 1'b0);
      send_beat(8'h79, 1'b0);
      send_beat(utp_pkg::BYTE_NEWLINE, 1'b0);
      send_code(21'h0FF21, 3);
      send_code(21'h0FF22, 3);
      finish_phase(1'b1);

      phase = 0;
      start = beats_sent;
      while (beats_sent - start < 40) begin
         case (phase)
            0: set_layout(16'hFFFF, 16'hFFFF);
            1: set_layout(16'd1, 16'd0);
            2: set_layout(16'd0, 16'd1);
            default: begin
               width_pick = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                            16'($urandom_range(1, 8));
               height_pick = 16'($urandom_range(0, 3));
               set_layout(width_pick, height_pick);
            end
         endcase
         repeat ($urandom_range(6, 16)) send_char();
         finish_phase($urandom_range(0, 3) != 0);
         phase++;
      end

      // every char that does not open a line wraps and ends a page, so the stalled receiver holds back the source
      set_layout(16'd1, 16'd1);
      hold_armed = 1'b1;
      steady = 1'b1;
      repeat (20) send_beat(8'($urandom_range(33, 126)), 1'b0);
      steady = 1'b0;
      finish_phase(1'b1);

      if (book.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
hdl/utp_pkg.sv
hdl/utp_channels.sv
hdl/utp_controller.sv
hdl/utp_datapath.sv
hdl/utf8_text_paginator.sv
sim/utf8_text_paginator_tb.sv
